// ===== hdl/rcsa_pkg.sv =====
// Shared types, constants and helper functions for the RC stick arming block.
// Used by rcsa_in_reg, rcsa_core and rc_stick_arming_mode_logic. No dependencies.
`timescale 1ns / 1ps

package rcsa_pkg;

  localparam int LEVEL_W     = 10;
  localparam int WIDTH_W     = 16;
  localparam int DT_W        = 16;
  localparam int HOLD_W      = 22;
  localparam int TIMER_W     = 23;
  localparam int NUM_CH      = 4;
  localparam int IN_TDATA_W  = 104;  // 101 bits of fields, padded to whole bytes
  localparam int OUT_TDATA_W = 8;    // 6 bits of fields, padded to a byte
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 22;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 10'd1000;
  localparam logic [WIDTH_W-1:0] WIDTH_OFS  = 16'd1000;
  localparam logic [TIMER_W-1:0] TIMER_MAX  = 23'h7FFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_LOW        = 3'd0,
    CFG_STICK_HIGH       = 3'd1,
    CFG_HOLD_TIME_US     = 3'd2,
    CFG_THROTTLE_STILL   = 3'd3,
    CFG_AUX_HOLD_Z       = 3'd4,
    CFG_AUX_HOLD_XY      = 3'd5,
    CFG_TAKEOFF_THROTTLE = 3'd6
  } rcsa_cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] stick_low;
    logic [LEVEL_W-1:0] stick_high;
    logic [HOLD_W-1:0]  hold_time_us;
    logic [LEVEL_W-1:0] throttle_still;
    logic [LEVEL_W-1:0] aux_hold_z;
    logic [LEVEL_W-1:0] aux_hold_xy;
    logic [LEVEL_W-1:0] takeoff_throttle;
  } rcsa_cfg_t;

  // One request after normalization: channel 0 roll, 1 pitch, 2 throttle, 3 yaw
  typedef struct packed {
    logic                            fresh;
    logic [NUM_CH-1:0][LEVEL_W-1:0]  chan;
    logic [LEVEL_W-1:0]              throttle_level;
    logic [LEVEL_W-1:0]              aux_level;
    logic [DT_W-1:0]                 elapsed_us;
    logic                            attitude_ready;
  } rcsa_item_t;

  typedef struct packed {
    logic latch_heading;
    logic latch_position;
    logic hold_horizontal;
    logic hold_height;
    logic taken_off;
    logic armed;
  } rcsa_res_t;

  // Pulse width in us -> per-mille, width minus 1000 clamped to 0..1000
  function automatic logic [LEVEL_W-1:0] norm_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] d;
    d = w - WIDTH_OFS;
    if (w <= WIDTH_OFS) begin
      return '0;
    end else if (d > WIDTH_W'(LEVEL_MAX)) begin
      return LEVEL_MAX;
    end else begin
      return d[LEVEL_W-1:0];
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] x);
    return (x > LEVEL_MAX) ? LEVEL_MAX : x;
  endfunction

endpackage

// ===== hdl/rcsa_in_reg.sv =====
// Input register: unpacks the request, normalizes widths and levels, holds one item.
// Depends on rcsa_pkg.
`timescale 1ns / 1ps

module rcsa_in_reg
  import rcsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  take,        // core consumes the held item
  output logic                  item_valid,
  output rcsa_item_t            item
);

  logic       valid_r, valid_nxt;
  rcsa_item_t item_r, item_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    item_nxt.fresh          = in_tuser;
    item_nxt.chan[0]        = norm_width(in_tdata[15:0]);
    item_nxt.chan[1]        = norm_width(in_tdata[31:16]);
    item_nxt.chan[2]        = norm_width(in_tdata[47:32]);
    item_nxt.chan[3]        = norm_width(in_tdata[63:48]);
    item_nxt.throttle_level = sat_level(in_tdata[73:64]);
    item_nxt.aux_level      = sat_level(in_tdata[83:74]);
    item_nxt.elapsed_us     = in_tdata[99:84];
    item_nxt.attitude_ready = in_tdata[100];
    valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/rcsa_core.sv =====
// Arming and hold-mode state plus the per-request next-state logic.
// Depends on rcsa_pkg.
`timescale 1ns / 1ps

module rcsa_core
  import rcsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,      // process item this cycle
  input  rcsa_item_t item,
  input  rcsa_cfg_t  cfg,
  output rcsa_res_t  res
);

  logic [NUM_CH-1:0][LEVEL_W-1:0] chan_r, chan_nxt;
  logic [LEVEL_W-1:0] held_thr_r, held_thr_nxt;
  logic [LEVEL_W-1:0] held_aux_r, held_aux_nxt;
  logic [LEVEL_W-1:0] prev_thr_r;
  logic [TIMER_W-1:0] arm_timer_r, arm_timer_nxt;
  logic [TIMER_W-1:0] height_timer_r, height_timer_nxt;
  logic armed_r, armed_nxt;
  logic takeoff_r, takeoff_nxt;
  logic hold_z_r, hold_z_nxt;
  logic hold_xy_r, hold_xy_nxt;

  logic               gesture;
  logic               steady;
  logic [LEVEL_W-1:0] thr_diff;
  logic [TIMER_W:0]   arm_sum, height_sum;
  logic [TIMER_W-1:0] hold_time;
  logic               latch_pos, latch_head;

  always_comb begin
    chan_nxt     = item.fresh ? item.chan           : chan_r;
    held_thr_nxt = item.fresh ? item.throttle_level : held_thr_r;
    held_aux_nxt = item.fresh ? item.aux_level      : held_aux_r;
    hold_time    = TIMER_W'(cfg.hold_time_us);

    // arm / disarm gesture: throttle, yaw, pitch low, roll high and attitude ready
    gesture = (chan_nxt[2] < cfg.stick_low) && (chan_nxt[3] < cfg.stick_low) &&
              (chan_nxt[1] < cfg.stick_low) && (chan_nxt[0] > cfg.stick_high) &&
              item.attitude_ready;
    arm_sum = {1'b0, arm_timer_r} + (TIMER_W + 1)'(item.elapsed_us);

    arm_timer_nxt = '0;
    armed_nxt     = armed_r;
    latch_head    = 1'b0;
    if (gesture) begin
      if (arm_timer_r < hold_time) begin
        arm_timer_nxt = arm_sum[TIMER_W] ? TIMER_MAX : arm_sum[TIMER_W-1:0];
      end else begin
        armed_nxt  = !armed_r;
        latch_head = armed_r;
      end
    end

    // height / horizontal hold, using last request's takeoff flag
    thr_diff   = (held_thr_nxt >= prev_thr_r) ? held_thr_nxt - prev_thr_r
                                              : prev_thr_r - held_thr_nxt;
    steady     = (thr_diff < cfg.throttle_still) && takeoff_r &&
                 (held_aux_nxt < cfg.aux_hold_z);
    height_sum = {1'b0, height_timer_r} + (TIMER_W + 1)'(item.elapsed_us);

    height_timer_nxt = height_timer_r;
    hold_z_nxt       = hold_z_r;
    hold_xy_nxt      = hold_xy_r;
    latch_pos        = 1'b0;
    if (steady) begin
      if (height_timer_r < hold_time) begin
        height_timer_nxt = height_sum[TIMER_W] ? TIMER_MAX : height_sum[TIMER_W-1:0];
      end else if (!hold_z_r) begin
        latch_pos  = 1'b1;
        hold_z_nxt = 1'b1;
        if (held_aux_nxt < cfg.aux_hold_xy) begin
          hold_xy_nxt = 1'b1;
        end
      end
    end else begin
      height_timer_nxt = '0;
      hold_z_nxt       = 1'b0;
      hold_xy_nxt      = 1'b0;
    end

    takeoff_nxt = (held_thr_nxt > cfg.takeoff_throttle) && !armed_nxt;

    res.armed           = armed_nxt;
    res.taken_off       = takeoff_nxt;
    res.hold_height     = hold_z_nxt;
    res.hold_horizontal = hold_xy_nxt;
    res.latch_position  = latch_pos;
    res.latch_heading   = latch_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r         <= '0;
      held_thr_r     <= '0;
      held_aux_r     <= '0;
      prev_thr_r     <= '0;
      arm_timer_r    <= '0;
      height_timer_r <= '0;
      armed_r        <= 1'b0;
      takeoff_r      <= 1'b0;
      hold_z_r       <= 1'b0;
      hold_xy_r      <= 1'b0;
    end else if (go) begin
      chan_r         <= chan_nxt;
      held_thr_r     <= held_thr_nxt;
      held_aux_r     <= held_aux_nxt;
      prev_thr_r     <= held_thr_nxt;
      arm_timer_r    <= arm_timer_nxt;
      height_timer_r <= height_timer_nxt;
      armed_r        <= armed_nxt;
      takeoff_r      <= takeoff_nxt;
      hold_z_r       <= hold_z_nxt;
      hold_xy_r      <= hold_xy_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_head_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.latch_heading |-> !res.armed)
    else $error("heading latch without disarm");
  a_pos_engages: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.latch_position |-> res.hold_height && !hold_z_r)
    else $error("position latch without height hold engaging");
  a_xy_needs_z: assert property (@(posedge clk) disable iff (!rst_n)
    hold_xy_r |-> hold_z_r)
    else $error("horizontal hold without height hold");
  a_takeoff_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    takeoff_r |-> !armed_r)
    else $error("takeoff flag set while armed");
`endif

endmodule

// ===== hdl/rc_stick_arming_mode_logic.sv =====
// Top level of the RC stick arming and hold-mode block: config registers,
// output register and stream handshake. Depends on rcsa_pkg, rcsa_in_reg, rcsa_core.
`timescale 1ns / 1ps

// Usage
//   One request per RC tick enters on the in_ stream; one result per request
//   leaves on the out_ stream, in order. in_tuser carries the fresh flag.
//   Widths are normalized on the way into the input register; the core then
//   updates the arm timer, height timer and mode flags and the result lands
//   in the output register.
//   An accepted request passes the input register, then the output register.
//   Throughput: one request per cycle while out_tready stays high; the input
//   register and the output register each hold one request, so a new request
//   is taken while a finished result still waits.
//   Stall: when out_tready is low and a result is waiting, the input register
//   fills and then in_tready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous): both registers empty, all mode state and
//   timers cleared, configuration back to its defaults.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index; write
//   only while no request is in flight. Unknown indexes are ignored.
module rc_stick_arming_mode_logic
  import rcsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // roll_width_us[15:0], pitch_width_us[31:16], throttle_width_us[47:32],
  // yaw_width_us[63:48], throttle_level[73:64], aux_level[83:74],
  // elapsed_us[99:84], attitude_ready[100], zero pad[103:101]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // fresh
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // armed[0], taken_off[1], hold_height[2], hold_horizontal[3],
  // latch_position[4], latch_heading[5], zero pad[7:6]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  rcsa_cfg_t  cfg_r;
  rcsa_item_t item;
  rcsa_res_t  res, res_r;
  logic       item_valid;
  logic       advance;      // output register can take a new result
  logic       go;           // core processes the held request
  logic       out_valid_r, out_valid_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_low        <= 10'd100;
      cfg_r.stick_high       <= 10'd800;
      cfg_r.hold_time_us     <= 22'd2000000;
      cfg_r.throttle_still   <= 10'd5;
      cfg_r.aux_hold_z       <= 10'd800;
      cfg_r.aux_hold_xy      <= 10'd200;
      cfg_r.takeoff_throttle <= 10'd150;
    end else if (cfg_wr_en) begin
      unique case (rcsa_cfg_idx_t'(cfg_index))
        CFG_STICK_LOW:        cfg_r.stick_low        <= cfg_wdata[LEVEL_W-1:0];
        CFG_STICK_HIGH:       cfg_r.stick_high       <= cfg_wdata[LEVEL_W-1:0];
        CFG_HOLD_TIME_US:     cfg_r.hold_time_us     <= cfg_wdata[HOLD_W-1:0];
        CFG_THROTTLE_STILL:   cfg_r.throttle_still   <= cfg_wdata[LEVEL_W-1:0];
        CFG_AUX_HOLD_Z:       cfg_r.aux_hold_z       <= cfg_wdata[LEVEL_W-1:0];
        CFG_AUX_HOLD_XY:      cfg_r.aux_hold_xy      <= cfg_wdata[LEVEL_W-1:0];
        CFG_TAKEOFF_THROTTLE: cfg_r.takeoff_throttle <= cfg_wdata[LEVEL_W-1:0];
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  // Stage control: the core runs only when its result has somewhere to go
  assign advance = !out_valid_r || out_tready;
  assign go      = item_valid && advance;

  rcsa_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (go),
    .item_valid (item_valid),
    .item       (item)
  );

  rcsa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register
  assign out_valid_nxt = advance ? go : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.latch_heading, res_r.latch_position,
                       res_r.hold_horizontal, res_r.hold_height,
                       res_r.taken_off, res_r.armed};

endmodule
